>>> rtl/stok_pkg.sv
// Package for the source tokenizer: result beat types, token kind codes
// and sizing constants. No dependencies.
package stok_pkg;

  localparam int OFFSET_BITS_DEF = 32;
  localparam int FIFO_DEPTH      = 4;
  localparam int KIND_W          = 9;
  localparam int OFS_OUT_W       = 32;
  localparam int ERR_W           = 2;
  localparam int TDATA_OUT_W     = 80;

  localparam logic [KIND_W-1:0] K_IDENT   = 9'd256;
  localparam logic [KIND_W-1:0] K_INT     = 9'd257;
  localparam logic [KIND_W-1:0] K_REAL    = 9'd258;
  localparam logic [KIND_W-1:0] K_COMMENT = 9'd259;
  localparam logic [KIND_W-1:0] K_STRING  = 9'd260;
  localparam logic [KIND_W-1:0] K_OP_ADD  = 9'd261;
  localparam logic [KIND_W-1:0] K_OP_SUB  = 9'd262;
  localparam logic [KIND_W-1:0] K_OP_MUL  = 9'd263;
  localparam logic [KIND_W-1:0] K_OP_DIV  = 9'd264;
  localparam logic [KIND_W-1:0] K_OP_EQ   = 9'd265;
  localparam logic [KIND_W-1:0] K_OP_NE   = 9'd266;
  localparam logic [KIND_W-1:0] K_OP_LE   = 9'd267;
  localparam logic [KIND_W-1:0] K_OP_GE   = 9'd268;

  typedef struct packed {
    logic                 run_final;
    logic [ERR_W-1:0]     error_count;
    logic [OFS_OUT_W-1:0] end_offset;
    logic [OFS_OUT_W-1:0] start_offset;
    logic [KIND_W-1:0]    token_kind;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    r1;
    result_t    r0;
  } scan_out_t;

endpackage

>>> rtl/stok_scan.sv
// Scanner state and per-byte next-state logic: up to two tokens per beat.
// Depends on stok_pkg.
module stok_scan #(
  parameter int OFFSET_BITS = stok_pkg::OFFSET_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          char_byte,
  input  logic                end_of_text,
  output stok_pkg::scan_out_t wr
);
  import stok_pkg::*;

  localparam logic [3:0] M_IDLE       = 4'd0;
  localparam logic [3:0] M_IDENT      = 4'd1;
  localparam logic [3:0] M_NUM        = 4'd2;
  localparam logic [3:0] M_EXP_FIRST  = 4'd3;
  localparam logic [3:0] M_EXP_SIGN   = 4'd4;
  localparam logic [3:0] M_EXP_DIGITS = 4'd5;
  localparam logic [3:0] M_COMMENT    = 4'd6;
  localparam logic [3:0] M_STRING     = 4'd7;
  localparam logic [3:0] M_OP         = 4'd8;
  localparam logic [3:0] M_DOT        = 4'd9;

  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LO_E  = 8'h65;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [KIND_W-1:0] op_kind(input logic [7:0] c);
    logic [KIND_W-1:0] k;
    case (c)
      CH_PLUS:  k = K_OP_ADD;
      CH_MINUS: k = K_OP_SUB;
      CH_STAR:  k = K_OP_MUL;
      CH_SLASH: k = K_OP_DIV;
      CH_EQ:    k = K_OP_EQ;
      CH_BANG:  k = K_OP_NE;
      CH_LT:    k = K_OP_LE;
      CH_GT:    k = K_OP_GE;
      default:  k = '0;
    endcase
    return k;
  endfunction

  function automatic logic [ERR_W-1:0] err_inc(input logic [ERR_W-1:0] e);
    return (e == 2'd2) ? 2'd2 : e + 2'd1;
  endfunction

  function automatic result_t mk(input logic [KIND_W-1:0] kind,
                                 input logic [OFFSET_BITS-1:0] s,
                                 input logic [OFFSET_BITS-1:0] e,
                                 input logic [ERR_W-1:0] errs);
    result_t r;
    r.token_kind   = kind;
    r.start_offset = OFS_OUT_W'(s);
    r.end_offset   = OFS_OUT_W'(e);
    r.error_count  = errs;
    r.run_final    = 1'b0;
    return r;
  endfunction

  logic [3:0]             mode, mode_next;
  logic [OFFSET_BITS-1:0] byte_offset, byte_offset_next;
  logic [OFFSET_BITS-1:0] token_start, token_start_next;
  logic [7:0]             held_byte, held_byte_next;
  logic [1:0]             dot_seen, dot_seen_next;
  logic [ERR_W-1:0]       errors_so_far, errors_so_far_next;

  logic [OFFSET_BITS-1:0] nxt;
  logic                   restart;
  logic                   a_v, b_v, c_v;
  result_t                a_r, b_r, c_r;
  logic [1:0]             n;

  assign nxt = byte_offset + OFFSET_BITS'(1);

  always_comb begin
    mode_next          = mode;
    token_start_next   = token_start;
    held_byte_next     = held_byte;
    dot_seen_next      = dot_seen;
    errors_so_far_next = errors_so_far;
    byte_offset_next   = nxt;
    restart = 1'b0;
    a_v = 1'b0;
    b_v = 1'b0;
    c_v = 1'b0;
    a_r = '0;
    b_r = '0;
    c_r = '0;

    unique case (mode)
      M_IDLE: restart = 1'b1;
      M_IDENT: begin
        if (!(is_alpha(char_byte) || is_digit(char_byte) || char_byte == CH_UNDER)) begin
          a_v = 1'b1;
          a_r = mk(K_IDENT, token_start, byte_offset, 2'd0);
          restart = 1'b1;
        end
      end
      M_NUM: begin
        if (is_digit(char_byte)) begin
        end else if (char_byte == CH_DOT) begin
          if (dot_seen == 2'd1) errors_so_far_next = err_inc(errors_so_far);
          if (dot_seen != 2'd2) dot_seen_next = dot_seen + 2'd1;
        end else if (char_byte == CH_LO_E || char_byte == CH_UP_E) begin
          mode_next = M_EXP_FIRST;
        end else begin
          a_v = 1'b1;
          a_r = mk((dot_seen != 2'd0) ? K_REAL : K_INT, token_start, byte_offset,
                   (dot_seen != 2'd0) ? errors_so_far : 2'd0);
          restart = 1'b1;
        end
      end
      M_EXP_FIRST: begin
        if (char_byte == CH_PLUS || char_byte == CH_MINUS) begin
          mode_next = M_EXP_SIGN;
        end else begin
          if (!is_digit(char_byte)) errors_so_far_next = err_inc(errors_so_far);
          mode_next = M_EXP_DIGITS;
        end
      end
      M_EXP_SIGN: begin
        if (is_digit(char_byte)) begin
          mode_next = M_EXP_DIGITS;
        end else begin
          a_v = 1'b1;
          a_r = mk(K_REAL, token_start, byte_offset, err_inc(errors_so_far));
          restart = 1'b1;
        end
      end
      M_EXP_DIGITS: begin
        if (!is_digit(char_byte)) begin
          a_v = 1'b1;
          a_r = mk(K_REAL, token_start, byte_offset, errors_so_far);
          restart = 1'b1;
        end
      end
      M_COMMENT: begin
        if (char_byte == CH_NUL || char_byte == CH_LF || char_byte == CH_CR) begin
          a_v = 1'b1;
          a_r = mk(K_COMMENT, token_start, byte_offset, 2'd0);
          restart = 1'b1;
        end
      end
      M_STRING: begin
        if (char_byte == CH_QUOTE) begin
          a_v = 1'b1;
          a_r = mk(K_STRING, token_start, nxt, 2'd0);
          mode_next = M_IDLE;
          held_byte_next = '0;
          dot_seen_next = '0;
          errors_so_far_next = '0;
        end
      end
      M_OP: begin
        a_v = 1'b1;
        if (char_byte == CH_EQ) begin
          a_r = mk(op_kind(held_byte), token_start, nxt, 2'd0);
          mode_next = M_IDLE;
          held_byte_next = '0;
          dot_seen_next = '0;
          errors_so_far_next = '0;
        end else begin
          a_r = mk({1'b0, held_byte}, token_start, byte_offset, 2'd0);
          restart = 1'b1;
        end
      end
      M_DOT: begin
        if (is_digit(char_byte)) begin
          mode_next = M_NUM;
          dot_seen_next = 2'd1;
        end else begin
          a_v = 1'b1;
          a_r = mk({1'b0, CH_DOT}, token_start, byte_offset, 2'd0);
          restart = 1'b1;
        end
      end
      default: restart = 1'b1;
    endcase

    if (restart) begin
      mode_next          = M_IDLE;
      held_byte_next     = '0;
      dot_seen_next      = '0;
      errors_so_far_next = '0;
      token_start_next   = byte_offset;
      if (is_space(char_byte)) begin
      end else if (is_alpha(char_byte)) begin
        mode_next = M_IDENT;
      end else if (is_digit(char_byte)) begin
        mode_next = M_NUM;
      end else if (char_byte == CH_DOT) begin
        mode_next = M_DOT;
      end else if (char_byte == CH_HASH) begin
        mode_next = M_COMMENT;
      end else if (char_byte == CH_QUOTE) begin
        mode_next = M_STRING;
      end else if (op_kind(char_byte) != '0) begin
        mode_next = M_OP;
        held_byte_next = char_byte;
      end else begin
        b_v = 1'b1;
        b_r = mk({1'b0, char_byte}, byte_offset, nxt, 2'd0);
      end
    end

    if (end_of_text) begin
      c_v = 1'b1;
      unique case (mode_next)
        M_IDENT:      c_r = mk(K_IDENT, token_start_next, nxt, 2'd0);
        M_NUM:        c_r = mk((dot_seen_next != 2'd0) ? K_REAL : K_INT, token_start_next,
                               nxt, (dot_seen_next != 2'd0) ? errors_so_far_next : 2'd0);
        M_EXP_FIRST,
        M_EXP_SIGN:   c_r = mk(K_REAL, token_start_next, nxt, err_inc(errors_so_far_next));
        M_EXP_DIGITS: c_r = mk(K_REAL, token_start_next, nxt, errors_so_far_next);
        M_COMMENT:    c_r = mk(K_COMMENT, token_start_next, nxt, 2'd0);
        M_STRING:     c_r = mk(K_STRING, token_start_next, nxt, 2'd0);
        M_OP:         c_r = mk({1'b0, held_byte_next}, token_start_next, nxt, 2'd0);
        M_DOT:        c_r = mk({1'b0, CH_DOT}, token_start_next, nxt, 2'd0);
        default:      c_v = 1'b0;
      endcase
      mode_next          = M_IDLE;
      held_byte_next     = '0;
      dot_seen_next      = '0;
      errors_so_far_next = '0;
      token_start_next   = '0;
      byte_offset_next   = '0;
    end
  end

  assign n = accept ? (2'(a_v) + 2'(b_v) + 2'(c_v)) : 2'd0;

  always_comb begin
    wr.cnt = n;
    wr.r0  = a_v ? a_r : (b_v ? b_r : c_r);
    wr.r1  = (a_v && b_v) ? b_r : c_r;
    wr.r0.run_final = (n == 2'd1);
    wr.r1.run_final = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= M_IDLE;
      byte_offset   <= '0;
      token_start   <= '0;
      held_byte     <= '0;
      dot_seen      <= '0;
      errors_so_far <= '0;
    end else if (accept) begin
      mode          <= mode_next;
      byte_offset   <= byte_offset_next;
      token_start   <= token_start_next;
      held_byte     <= held_byte_next;
      dot_seen      <= dot_seen_next;
      errors_so_far <= errors_so_far_next;
    end
  end

endmodule

>>> rtl/stok_fifo.sv
// Result queue: takes up to two token beats per cycle, releases one.
// Depends on stok_pkg.
module stok_fifo (
  input  logic                clk,
  input  logic                rst,
  input  stok_pkg::scan_out_t wr,
  output logic                can_take,
  output logic                out_valid,
  input  logic                out_ready,
  output stok_pkg::result_t   head
);
  import stok_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  result_t          ent [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   fill, fill_next;
  logic             pop;

  assign out_valid = fill != '0;
  assign pop       = out_valid && out_ready;
  assign can_take  = fill <= (PTR_W + 1)'(FIFO_DEPTH - 2);
  assign head      = ent[rd_ptr];
  assign fill_next = fill + (PTR_W + 1)'(wr.cnt) - (PTR_W + 1)'(pop);

  always_ff @(posedge clk) begin
    if (wr.cnt != 2'd0) ent[wr_ptr] <= wr.r0;
    if (wr.cnt == 2'd2) ent[wr_ptr + PTR_W'(1)] <= wr.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(wr.cnt);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      fill   <= fill_next;
    end
  end

endmodule

>>> rtl/source_tokenizer.sv
// Top level of the source tokenizer: byte stream in, token stream out.
// Depends on stok_pkg, stok_scan and stok_fifo.
//
// Input channel s_*: one source byte per beat; s_tlast marks the last byte
// of a buffer and flushes any pending token, after which offsets restart
// at zero. Output channel m_*: one token per beat with its kind, start and
// end offsets and number-format error count; m_tlast marks the last token
// caused by one input byte.
// A token is written to the result queue when the byte that ends it is accepted.
// Throughput: one byte per cycle while the output drains; a byte that
// yields two tokens sends them out one per beat. The scanner does all work for
// a byte combinationally between its state registers and a four-entry result
// queue, and accepts a byte whenever at least two queue entries are free.
// Reset clears the scanner to idle, offsets to zero and empties the queue.
// When the receiver stalls, queued tokens hold and s_tready drops once
// fewer than two entries remain free; no token is lost.
module source_tokenizer #(
  parameter int OFFSET_BITS = stok_pkg::OFFSET_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,  // char_byte
  input  logic                               s_tlast,  // end_of_text
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // token_kind, start_offset, end_offset, error_count, zero pad
  output logic [stok_pkg::TDATA_OUT_W-1:0]   m_tdata,
  output logic                               m_tlast   // run_final
);
  import stok_pkg::*;

  localparam int PAD_W = TDATA_OUT_W - KIND_W - 2 * OFS_OUT_W - ERR_W;

  scan_out_t wr;
  result_t   head;
  logic      can_take;
  logic      accept;

  assign s_tready = can_take && !rst;
  assign accept   = s_tvalid && s_tready;

  stok_scan #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .char_byte  (s_tdata),
    .end_of_text(s_tlast),
    .wr         (wr)
  );

  stok_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .can_take (can_take),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .head     (head)
  );

  assign m_tdata = {PAD_W'(0), head.error_count, head.end_offset, head.start_offset,
                    head.token_kind};
  assign m_tlast = head.run_final;

endmodule

>>> rtl/stok_chk.sv
// Port-level checks for the source tokenizer, bound to the top level.
// Depends on stok_pkg and source_tokenizer.
module stok_chk (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic [7:0]                       s_tdata,
  input logic                             s_tlast,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [stok_pkg::TDATA_OUT_W-1:0] m_tdata,
  input logic                             m_tlast
);
  import stok_pkg::*;

  localparam int ERR_LO = KIND_W + 2 * OFS_OUT_W;

  logic [KIND_W-1:0] kind;
  logic [ERR_W-1:0]  errs;

  assign kind = m_tdata[KIND_W-1:0];
  assign errs = m_tdata[ERR_LO + ERR_W - 1:ERR_LO];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled token beat changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |-> !s_tready ##1 !m_tvalid)
    else $error("queue not empty after reset");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> kind <= K_OP_GE && errs != 2'd3)
    else $error("token kind or error count out of range");

  a_err_real_only: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && kind != K_REAL |-> errs == 2'd0)
    else $error("error count on a token that is not a real number");

endmodule

bind source_tokenizer stok_chk u_chk (.*);

>>> test/tb_source_tokenizer.sv
// Self-checking testbench for source_tokenizer: streams source bytes, predicts
// every token with a scanner model of its own and checks each output beat.
// Depends on stok_pkg and the source_tokenizer RTL.
module tb_source_tokenizer;
  import stok_pkg::*;

  typedef enum logic [3:0] {
    SCAN_IDLE, SCAN_IDENT, SCAN_NUM, SCAN_EXP_FIRST, SCAN_EXP_SIGN,
    SCAN_EXP_DIGITS, SCAN_COMMENT, SCAN_STRING, SCAN_OP, SCAN_DOT
  } scan_mode_e;

  class token_scoreboard;
    scan_mode_e  mode;
    logic [31:0] pos;
    logic [31:0] tok_start;
    logic [7:0]  held;
    logic [1:0]  dots;
    logic [1:0]  errs;
    result_t     due[$];
    int unsigned fails;
    int unsigned matched;

    function new();
      idle();
      pos = '0;
      tok_start = '0;
      fails = 0;
      matched = 0;
    endfunction

    static function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    static function bit is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    static function bit is_space(logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    static function logic [KIND_W-1:0] op_code(logic [7:0] c);
      case (c)
        "+": return K_OP_ADD;
        "-": return K_OP_SUB;
        "*": return K_OP_MUL;
        "/": return K_OP_DIV;
        "=": return K_OP_EQ;
        "!": return K_OP_NE;
        "<": return K_OP_LE;
        ">": return K_OP_GE;
        default: return '0;
      endcase
    endfunction

    function void idle();
      mode = SCAN_IDLE;
      held = '0;
      dots = '0;
      errs = '0;
    endfunction

    function void bump_error();
      if (errs < 2'd2) errs++;
    endfunction

    function void push(logic [KIND_W-1:0] kind, logic [31:0] s, logic [31:0] e,
                       logic [1:0] ec);
      result_t r;
      r.token_kind = kind;
      r.start_offset = s;
      r.end_offset = e;
      r.error_count = ec;
      r.run_final = 1'b0;
      due.push_back(r);
    endfunction

    function void close_number(logic [31:0] e, bit real_num);
      push(real_num ? K_REAL : K_INT, tok_start, e, real_num ? errs : 2'd0);
      idle();
    endfunction

    function void open_token(logic [7:0] c, logic [31:0] off);
      logic [31:0] nxt;
      nxt = off + 32'd1;
      idle();
      tok_start = off;
      if (is_space(c)) return;
      if (is_alpha(c)) mode = SCAN_IDENT;
      else if (is_digit(c)) mode = SCAN_NUM;
      else if (c == ".") mode = SCAN_DOT;
      else if (c == "#") mode = SCAN_COMMENT;
      else if (c == "\"") mode = SCAN_STRING;
      else if (op_code(c) != '0) begin
        mode = SCAN_OP;
        held = c;
      end else push({1'b0, c}, off, nxt, 2'd0);
    endfunction

    // Returns 1 when the byte ends the current token without joining it.
    function bit extend_token(logic [7:0] c, logic [31:0] off);
      logic [31:0] nxt;
      nxt = off + 32'd1;
      case (mode)
        SCAN_IDENT: begin
          if (is_alpha(c) || is_digit(c) || c == "_") return 1'b0;
          push(K_IDENT, tok_start, off, 2'd0);
          idle();
          return 1'b1;
        end
        SCAN_NUM: begin
          if (is_digit(c)) return 1'b0;
          if (c == ".") begin
            if (dots == 2'd1) bump_error();
            if (dots < 2'd2) dots++;
            return 1'b0;
          end
          if (c == "e" || c == "E") begin
            mode = SCAN_EXP_FIRST;
            return 1'b0;
          end
          close_number(off, dots != 2'd0);
          return 1'b1;
        end
        SCAN_EXP_FIRST: begin
          if (c == "+" || c == "-") mode = SCAN_EXP_SIGN;
          else begin
            if (!is_digit(c)) bump_error();
            mode = SCAN_EXP_DIGITS;
          end
          return 1'b0;
        end
        SCAN_EXP_SIGN: begin
          if (is_digit(c)) begin
            mode = SCAN_EXP_DIGITS;
            return 1'b0;
          end
          bump_error();
          close_number(off, 1'b1);
          return 1'b1;
        end
        SCAN_EXP_DIGITS: begin
          if (is_digit(c)) return 1'b0;
          close_number(off, 1'b1);
          return 1'b1;
        end
        SCAN_COMMENT: begin
          if (c == 8'h00 || c == "\n" || c == "\r") begin
            push(K_COMMENT, tok_start, off, 2'd0);
            idle();
            return 1'b1;
          end
          return 1'b0;
        end
        SCAN_STRING: begin
          if (c == "\"") begin
            push(K_STRING, tok_start, nxt, 2'd0);
            idle();
          end
          return 1'b0;
        end
        SCAN_OP: begin
          if (c == "=") begin
            push(op_code(held), tok_start, nxt, 2'd0);
            idle();
            return 1'b0;
          end
          push({1'b0, held}, tok_start, off, 2'd0);
          idle();
          return 1'b1;
        end
        SCAN_DOT: begin
          if (is_digit(c)) begin
            mode = SCAN_NUM;
            dots = 2'd1;
            return 1'b0;
          end
          push({1'b0, 8'h2E}, tok_start, off, 2'd0);
          idle();
          return 1'b1;
        end
        default: begin
          idle();
          return 1'b1;
        end
      endcase
    endfunction

    function void flush(logic [31:0] e);
      case (mode)
        SCAN_IDENT: push(K_IDENT, tok_start, e, 2'd0);
        SCAN_NUM: close_number(e, dots != 2'd0);
        SCAN_EXP_FIRST, SCAN_EXP_SIGN: begin
          bump_error();
          close_number(e, 1'b1);
        end
        SCAN_EXP_DIGITS: close_number(e, 1'b1);
        SCAN_COMMENT: push(K_COMMENT, tok_start, e, 2'd0);
        SCAN_STRING: push(K_STRING, tok_start, e, 2'd0);
        SCAN_OP: push({1'b0, held}, tok_start, e, 2'd0);
        SCAN_DOT: push({1'b0, 8'h2E}, tok_start, e, 2'd0);
        default: ;
      endcase
      idle();
    endfunction

    function void note_byte(logic [7:0] c, bit eot);
      logic [31:0] off;
      logic [31:0] nxt;
      int base;
      off = pos;
      nxt = pos + 32'd1;
      base = due.size();
      if (mode == SCAN_IDLE || extend_token(c, off)) open_token(c, off);
      if (eot) begin
        flush(nxt);
        pos = '0;
        tok_start = '0;
      end else begin
        pos = nxt;
      end
      if (due.size() > base) due[due.size()-1].run_final = 1'b1;
    endfunction

    function void check_token(result_t got);
      result_t want;
      if (due.size() == 0) begin
        $error("unexpected token: token_kind %0d start_offset %0d",
               got.token_kind, got.start_offset);
        fails++;
        return;
      end
      want = due.pop_front();
      matched++;
      if (got.token_kind !== want.token_kind) begin
        $error("token_kind expected %0d got %0d", want.token_kind, got.token_kind);
        fails++;
      end
      if (got.start_offset !== want.start_offset) begin
        $error("start_offset expected %0d got %0d", want.start_offset, got.start_offset);
        fails++;
      end
      if (got.end_offset !== want.end_offset) begin
        $error("end_offset expected %0d got %0d", want.end_offset, got.end_offset);
        fails++;
      end
      if (got.error_count !== want.error_count) begin
        $error("error_count expected %0d got %0d", want.error_count, got.error_count);
        fails++;
      end
      if (got.run_final !== want.run_final) begin
        $error("run_final expected %0d got %0d", want.run_final, got.run_final);
        fails++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [7:0]             s_tdata = '0;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_tdata;
  logic                   m_tlast;

  token_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;
  int unsigned bytes_sent = 0;
  int unsigned buffers_sent = 0;
  logic [7:0]  line_bytes[$];

  source_tokenizer u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // char_byte
    .s_tlast  (s_tlast),   // end_of_text
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // token_kind, start_offset, end_offset, error_count
    .m_tlast  (m_tlast)    // run_final
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    result_t got;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got.token_kind   = m_tdata[8:0];
        got.start_offset = m_tdata[40:9];
        got.end_offset   = m_tdata[72:41];
        got.error_count  = m_tdata[74:73];
        got.run_final    = m_tlast;
        sb.check_token(got);
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] c, input bit eot);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    s_tlast <= eot;
    do @(posedge clk); while (!s_tready);
    sb.note_byte(c, eot);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input bit eot);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eot && i == s.len() - 1);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(1) ? 8'($urandom_range(8'h61, 8'h7A))
                             : 8'($urandom_range(8'h41, 8'h5A));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'($urandom_range(8'h30, 8'h39));
  endfunction

  function automatic logic [7:0] rand_print();
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  function automatic void add_token();
    string ops = "+-*/=!<>";
    string punct = ".,;:()[]{}@$%&";
    int pick;
    logic [7:0] c;
    pick = $urandom_range(99);
    if (pick < 18) begin
      line_bytes.push_back(rand_letter());
      repeat ($urandom_range(5)) begin
        case ($urandom_range(2))
          0: line_bytes.push_back(rand_letter());
          1: line_bytes.push_back(rand_digit());
          default: line_bytes.push_back("_");
        endcase
      end
    end else if (pick < 34) begin
      if ($urandom_range(6) == 0) line_bytes.push_back(".");
      repeat ($urandom_range(1, 3)) line_bytes.push_back(rand_digit());
      if ($urandom_range(2) == 0) begin
        line_bytes.push_back(".");
        repeat ($urandom_range(2)) line_bytes.push_back(rand_digit());
        if ($urandom_range(4) == 0) begin
          line_bytes.push_back(".");
          line_bytes.push_back(rand_digit());
        end
      end
      if ($urandom_range(2) == 0) begin
        line_bytes.push_back($urandom_range(1) ? "e" : "E");
        case ($urandom_range(3))
          0: ;
          1: line_bytes.push_back("+");
          2: line_bytes.push_back("-");
          default: line_bytes.push_back(rand_letter());
        endcase
        repeat ($urandom_range(2)) line_bytes.push_back(rand_digit());
      end
    end else if (pick < 41) begin
      line_bytes.push_back("#");
      repeat ($urandom_range(6)) line_bytes.push_back(rand_print());
      case ($urandom_range(3))
        0: line_bytes.push_back("\n");
        1: line_bytes.push_back("\r");
        2: line_bytes.push_back(8'h00);
        default: ;
      endcase
    end else if (pick < 49) begin
      line_bytes.push_back("\"");
      repeat ($urandom_range(6)) begin
        c = rand_print();
        line_bytes.push_back(c == "\"" ? "'" : c);
      end
      if ($urandom_range(6) != 0) line_bytes.push_back("\"");
    end else if (pick < 64) begin
      line_bytes.push_back(ops[$urandom_range(7)]);
      if ($urandom_range(1)) line_bytes.push_back("=");
    end else if (pick < 78) begin
      line_bytes.push_back($urandom_range(1) ? " " : 8'($urandom_range(9, 13)));
    end else if (pick < 87) begin
      line_bytes.push_back(punct[$urandom_range(punct.len() - 1)]);
    end else begin
      line_bytes.push_back(8'($urandom_range(255)));
    end
  endfunction

  task automatic send_buffer();
    int target;
    target = $urandom_range(3) == 0 ? $urandom_range(1, 4) : $urandom_range(5, 40);
    line_bytes.delete();
    while (line_bytes.size() < target) add_token();
    for (int i = 0; i < line_bytes.size(); i++)
      send_byte(line_bytes[i], i == line_bytes.size() - 1);
    buffers_sent++;
  endtask

  task automatic run_phase(input int unsigned sp, input int unsigned rp,
                           input int unsigned n);
    int unsigned first;
    send_idle_pct = sp;
    recv_stall_pct = rp;
    first = bytes_sent;
    while (bytes_sent - first < n) send_buffer();
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // number with a second dot and a sign at end of text
    send_text("9..1e+", 1'b1);
    // lone dot, comment cut by a zero byte, unterminated string
    send_text(".x#", 1'b0);
    send_byte(8'h00, 1'b0);
    send_text("\"q", 1'b1);
    // operator, operator start followed by a high byte, sign with no digit
    send_text("<=!", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("1e- ", 1'b1);
    // bad exponent start
    send_text("1ez\n", 1'b1);
    drain();

    run_phase(0, 0, 300);
    run_phase(77, 0, 300);
    run_phase(0, 77, 300);
    run_phase(14, 14, 300);

    // hold the output long enough to back up the queue into the input
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 400;
    while (bytes_sent < 1345) send_buffer();
    drain();

    repeat (20) @(posedge clk);
    $display("Sent %0d source bytes in %0d buffers; checked %0d tokens", bytes_sent,
             buffers_sent, sb.matched);
    $display("Covered free flow, input gaps, output stalls, mixed idling and a long hold.");
    if (sb.fails == 0 && sb.due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/stok_pkg.sv
rtl/stok_scan.sv
rtl/stok_fifo.sv
rtl/source_tokenizer.sv
rtl/stok_chk.sv
test/tb_source_tokenizer.sv
